// ----- src/radix_prefixed_integer_parser_defines.svh -----
// Assertion macros for the radix prefixed integer parser.
// Used by the checker module only; no other dependencies.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_DEFINES_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_DEFINES_SVH

// Checked only outside reset
`define RPIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define RPIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/rpip_pkg.sv -----
// Package for the radix prefixed integer parser: phase type, state and
// result structs, character constants and the digit decode function.
package rpip_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] ALPHA_BASE   = 8'd17;
    localparam logic [7:0] ALPHA_OFFSET = 8'd7;
    localparam logic [7:0] DEC_MAX      = 8'd9;

    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    typedef struct packed {
        t_phase                 phase;
        logic                   negative;
        logic [4:0]             radix;
        logic [VALUE_WIDTH-1:0] acc;
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic                 ok;
        logic [OUT_WIDTH-1:0] value;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [7:0] digit;
    } t_digit;

    // ':' to '@' decode to 10..16, as the alphabetic range does
    function automatic t_digit decode_digit(input logic [7:0] c);
        t_digit     r;
        logic [7:0] t;
        t = c;
        if (t >= CH_LOWER_A) begin
            t = t - CASE_OFFSET;
        end
        t = t - CH_ZERO;
        r.ok = 1'b1;
        if (t >= ALPHA_BASE) begin
            t = t - ALPHA_OFFSET;
            if (t <= DEC_MAX) begin
                r.ok = 1'b0;
            end
        end
        r.digit = t;
        return r;
    endfunction

    // acc * radix + digit, radix being one of the four prefixes
    function automatic logic [VALUE_WIDTH-1:0] mul_add(
        input logic [VALUE_WIDTH-1:0] acc,
        input logic [4:0]             radix,
        input logic [7:0]             digit
    );
        logic [VALUE_WIDTH-1:0] p;
        case (radix)
            RADIX_BIN: p = acc << 1;
            RADIX_OCT: p = acc << 3;
            RADIX_DEC: p = (acc << 3) + (acc << 1);
            default:   p = acc << 4;
        endcase
        return p + VALUE_WIDTH'(digit);
    endfunction

endpackage

// ----- src/rpip_step.sv -----
// Next-state and result logic for one character of the parser.
// Depends on rpip_pkg.
module rpip_step
    import rpip_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char,
    output t_state     o_state,
    output t_result    o_result
);

    t_digit                        dg;
    logic                          is_dec;
    logic                          take_ok;
    logic [7:0]                    first_digit;
    logic [VALUE_WIDTH-1:0]        mag;
    logic signed [VALUE_WIDTH-1:0] sval;
    t_state                        start_state;

    always_comb begin
        start_state          = '0;
        start_state.phase    = PH_START;
        dg                   = decode_digit(i_char);
        is_dec               = i_char inside {[CH_ZERO:CH_NINE]};
        take_ok              = dg.ok && (dg.digit < 8'(i_state.radix));
        first_digit          = i_char - CH_ZERO;
        mag                  = i_state.negative ? (-i_state.acc) : i_state.acc;
        sval                 = signed'(mag);

        o_state  = i_state;
        o_result = '0;

        case (i_state.phase)
            PH_START, PH_SIGNED: begin
                if (i_state.phase == PH_START && i_char == CH_SPACE) begin
                    o_state = i_state;
                end else if (i_state.phase == PH_START && i_char == CH_MINUS) begin
                    o_state.negative = 1'b1;
                    o_state.phase    = PH_SIGNED;
                end else if (i_char == CH_ZERO) begin
                    o_state.phase = PH_ZERO;
                end else if (!is_dec) begin
                    o_result.valid = 1'b1;
                    o_state        = start_state;
                end else begin
                    o_state.radix = RADIX_DEC;
                    o_state.acc   = VALUE_WIDTH'(first_digit);
                    o_state.phase = PH_DIGITS;
                end
            end
            PH_ZERO: begin
                o_state.acc = '0;
                if (i_char == CH_LOWER_X) begin
                    o_state.radix = RADIX_HEX;
                    o_state.phase = PH_DIGITS;
                end else if (i_char == CH_LOWER_B) begin
                    o_state.radix = RADIX_BIN;
                    o_state.phase = PH_DIGITS;
                end else if (i_char <= CH_SPACE) begin
                    o_result.valid = 1'b1;
                    o_result.ok    = 1'b1;
                    o_state        = start_state;
                end else if (is_dec && first_digit < 8'(RADIX_OCT)) begin
                    o_state.radix = RADIX_OCT;
                    o_state.acc   = VALUE_WIDTH'(first_digit);
                    o_state.phase = PH_DIGITS;
                end else begin
                    o_result.valid = 1'b1;
                    o_state        = start_state;
                end
            end
            default: begin
                if (i_char <= CH_SPACE) begin
                    o_result.valid = 1'b1;
                    o_result.ok    = 1'b1;
                    o_result.value = OUT_WIDTH'(sval);
                    o_state        = start_state;
                end else if (take_ok) begin
                    o_state.acc = mul_add(i_state.acc, i_state.radix, dg.digit);
                end else begin
                    o_result.valid = 1'b1;
                    o_state        = start_state;
                end
            end
        endcase
    end

endmodule

// ----- src/radix_prefixed_integer_parser.sv -----
// Radix prefixed integer parser, top level: input register, parse state
// and result register. Depends on rpip_pkg and rpip_step.
// The character that ends a token is held in the input register; its result is then captured in the result register.
// Throughput: one character per cycle while no result is held by stall; the parse state updates once per character.
// A character waits in the input register only while a result is held by stall.
// Synchronous active-low reset empties both registers and returns to the start phase.
module radix_prefixed_integer_parser
    import rpip_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_code,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ok,
    output logic [OUT_WIDTH-1:0] o_value
);

    logic                 r_in_valid;
    logic [7:0]           r_in_char;
    t_state               r_state;
    t_state               n_state;
    t_result              n_result;
    logic                 r_out_valid;
    logic                 r_out_ok;
    logic [OUT_WIDTH-1:0] r_out_value;
    logic                 proc_go;

    rpip_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign proc_go    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_START, negative: 1'b0, radix: '0, acc: '0};
        end else if (proc_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && n_result.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_go && n_result.valid) begin
            r_out_ok    <= n_result.ok;
            r_out_value <= n_result.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out_ok;
    assign o_value     = r_out_value;

endmodule

// ----- src/rpip_checker.sv -----
// Port-level checks for the radix prefixed integer parser, bound to the top.
// Depends on rpip_pkg and radix_prefixed_integer_parser_defines.svh.
`include "radix_prefixed_integer_parser_defines.svh"

module rpip_checker
    import rpip_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [7:0]           i_char_code,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_ok,
    input logic [OUT_WIDTH-1:0] o_value
);

    `RPIP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result shown after reset")
    `RPIP_ASSERT(a_fail_zero, (o_out_valid && !o_ok) |-> (o_value == '0), "failure value not zero")
    `RPIP_ASSERT(a_stall_cause, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without held result")
    `RPIP_ASSERT(a_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_ok) && $stable(o_value)), "stalled result changed")
    `RPIP_ASSERT(a_in_hold, (i_in_valid && o_in_stall) |=> $stable(i_char_code), "stalled request changed")

endmodule

bind radix_prefixed_integer_parser rpip_checker u_rpip_checker (.*);

// ----- dv/parser_check_pkg.sv -----
`timescale 1ns / 100ps
// Token scoreboard for the radix prefixed integer parser: predicts each token
// result from the accepted characters and checks the results that come out.
// Depends on rpip_pkg for the phase type, character constants and widths.
package parser_check_pkg;
    import rpip_pkg::*;

    typedef struct {
        bit                   ok;
        logic [OUT_WIDTH-1:0] value;
    } t_token_result;

    class token_scoreboard;
        t_token_result          parsed_results_q[$];
        int                     errors;
        t_phase                 phase;
        bit                     negative;
        logic [4:0]             radix;
        logic [VALUE_WIDTH-1:0] acc;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase    = PH_START;
            negative = 1'b0;
            radix    = '0;
            acc      = '0;
        endfunction

        function void close_token(bit ok, logic [OUT_WIDTH-1:0] value);
            t_token_result r;
            r.ok    = ok;
            r.value = value;
            parsed_results_q.push_back(r);
            restart();
        endfunction

        function void close_good();
            logic [VALUE_WIDTH-1:0] v;
            v = negative ? -acc : acc;
            close_token(1'b1, OUT_WIDTH'($signed(v)));
        endfunction

        // returns 0 when the character is no digit of the current radix
        function bit add_digit(logic [7:0] ch);
            logic [7:0] d;
            d = ch;
            if (d >= CH_LOWER_A) begin
                d = d - CASE_OFFSET;
            end
            d = d - CH_ZERO;
            if (d >= ALPHA_BASE) begin
                d = d - ALPHA_OFFSET;
                if (d <= DEC_MAX) begin
                    return 1'b0;
                end
            end
            if (d >= {3'b000, radix}) begin
                return 1'b0;
            end
            acc = acc * VALUE_WIDTH'(radix) + VALUE_WIDTH'(d);
            return 1'b1;
        endfunction

        function void first_char(logic [7:0] ch);
            if (ch == CH_ZERO) begin
                phase = PH_ZERO;
            end else if (ch < CH_ZERO || ch > CH_NINE) begin
                close_token(1'b0, '0);
            end else begin
                radix = RADIX_DEC;
                acc   = '0;
                phase = PH_DIGITS;
                void'(add_digit(ch));
            end
        endfunction

        function void note_char(logic [7:0] ch);
            case (phase)
                PH_START: begin
                    if (ch == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = PH_SIGNED;
                    end else if (ch != CH_SPACE) begin
                        first_char(ch);
                    end
                end
                PH_SIGNED: first_char(ch);
                PH_ZERO: begin
                    acc = '0;
                    if (ch == CH_LOWER_X) begin
                        radix = RADIX_HEX;
                        phase = PH_DIGITS;
                    end else if (ch == CH_LOWER_B) begin
                        radix = RADIX_BIN;
                        phase = PH_DIGITS;
                    end else if (ch <= CH_SPACE) begin
                        close_token(1'b1, '0);
                    end else if (ch < CH_ZERO || ch > CH_NINE) begin
                        close_token(1'b0, '0);
                    end else begin
                        radix = RADIX_OCT;
                        phase = PH_DIGITS;
                        if (!add_digit(ch)) begin
                            close_token(1'b0, '0);
                        end
                    end
                end
                default: begin
                    if (ch <= CH_SPACE) begin
                        close_good();
                    end else if (!add_digit(ch)) begin
                        close_token(1'b0, '0);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic ok, logic [OUT_WIDTH-1:0] value);
            t_token_result e;
            if (parsed_results_q.size() == 0) begin
                report($sformatf("unexpected result ok=%0b value=%h", ok, value));
                return;
            end
            e = parsed_results_q.pop_front();
            if (ok !== e.ok) begin
                report($sformatf("ok %0b, expected %0b", ok, e.ok));
            end
            if (value !== e.value) begin
                report($sformatf("value %h, expected %h", value, e.value));
            end
        endtask
    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the parser testbench: clock, reset, request driver, result sink,
// watchdog and stimulus. Depends on rpip_pkg and parser_check_pkg.
module tb_top;
    import rpip_pkg::*;
    import parser_check_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CHARS_PER_PHASE = 250;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_char_code;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_ok;
    logic [OUT_WIDTH-1:0] o_value;

    token_scoreboard sb;
    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    bit              hold_off      = 1'b0;
    int              chars_sent    = 0;
    int              quiet_cycles  = 0;

    radix_prefixed_integer_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_value     (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stall, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_ok, o_value);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_char(logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_char_code <= 8'($urandom);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_char(ch);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[k]) begin
            send_char(s[k]);
        end
    endtask

    // occasionally corrupt a character to break the token
    task automatic send_token_char(logic [7:0] ch);
        if ($urandom_range(99) < 3) begin
            send_char(8'($urandom));
        end else begin
            send_char(ch);
        end
    endtask

    function automatic logic [7:0] digit_char(int v);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        case ($urandom_range(2))
            0:       return CH_LOWER_A + 8'(v - 10);
            1:       return CH_LOWER_A - CASE_OFFSET + 8'(v - 10);
            default: return CH_NINE + 8'(v - 9);
        endcase
    endfunction

    task automatic send_token();
        int         kind;
        int         ndig;
        logic [4:0] base;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom));
            return;
        end
        kind = $urandom_range(3);
        if ($urandom_range(9) == 0) begin
            ndig = $urandom_range(17, 70);
        end else begin
            ndig = (kind == 1 || kind == 2) ? $urandom_range(0, 8) : $urandom_range(1, 8);
        end
        repeat ($urandom_range(2)) send_token_char(CH_SPACE);
        if ($urandom_range(9) < 3) begin
            send_token_char(CH_MINUS);
        end
        case (kind)
            0: begin
                base = RADIX_DEC;
                send_token_char(digit_char($urandom_range(1, 9)));
                ndig--;
            end
            1: begin
                base = RADIX_HEX;
                send_token_char(CH_ZERO);
                send_token_char(CH_LOWER_X);
            end
            2: begin
                base = RADIX_BIN;
                send_token_char(CH_ZERO);
                send_token_char(CH_LOWER_B);
            end
            default: begin
                base = RADIX_OCT;
                send_token_char(CH_ZERO);
            end
        endcase
        repeat (ndig) send_token_char(digit_char($urandom_range(int'(base) - 1)));
        send_token_char(8'($urandom_range(32)));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.parsed_results_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lone zeros, bare prefixes, bad starts, octal nine, colon range hex
        send_text(" 0 ");
        send_text("-0");
        send_char(8'h00);
        send_text("0x\t");
        send_text("0b ");
        send_text("0q09");
        send_char(8'hFF);
        send_text("0x:? -9 ");
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  hold_off = 1'b1; end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            while (chars_sent < CHARS_PER_PHASE * (p + 1)) begin
                send_token();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.parsed_results_q.size() != 0) begin
            sb.report($sformatf("%0d results never came", sb.parsed_results_q.size()));
        end
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
